// ===== rtl/asl_pkg.sv =====
// ----------------------------------------------------------------------------
// asl_pkg
// Types, codes and step functions for the assembly source lexer.
// ----------------------------------------------------------------------------
package asl_pkg;

  localparam int LINE_WIDTH   = 20;
  localparam int COLUMN_WIDTH = 16;
  localparam int OFFSET_WIDTH = 24;
  localparam int LENGTH_WIDTH = 16;
  localparam int MAX_RES      = 4;

  // classifier states
  localparam logic [4:0] CS_EMPTY = 5'd0;
  localparam logic [4:0] CS_ZERO  = 5'd1;
  localparam logic [4:0] CS_DEC   = 5'd2;
  localparam logic [4:0] CS_FDOT  = 5'd3;
  localparam logic [4:0] CS_FLT   = 5'd4;
  localparam logic [4:0] CS_HEXP  = 5'd5;
  localparam logic [4:0] CS_HEX   = 5'd6;
  localparam logic [4:0] CS_BINP  = 5'd7;
  localparam logic [4:0] CS_BIN   = 5'd8;
  localparam logic [4:0] CS_OCTP  = 5'd9;
  localparam logic [4:0] CS_OCT   = 5'd10;
  localparam logic [4:0] CS_NAME  = 5'd11;
  localparam logic [4:0] CS_LABEL = 5'd12;
  localparam logic [4:0] CS_AT    = 5'd13;
  localparam logic [4:0] CS_REF   = 5'd14;
  localparam logic [4:0] CS_DEAD  = 5'd15;
  localparam logic [4:0] CS_SOPEN = 5'd16;
  localparam logic [4:0] CS_SDONE = 5'd17;
  localparam logic [4:0] CS_SBAD  = 5'd18;

  localparam logic [3:0] K_FLOAT   = 4'd0;
  localparam logic [3:0] K_INT     = 4'd1;
  localparam logic [3:0] K_STRING  = 4'd2;
  localparam logic [3:0] K_NAME    = 4'd3;
  localparam logic [3:0] K_LABEL   = 4'd4;
  localparam logic [3:0] K_REF     = 4'd5;
  localparam logic [3:0] K_SYMBOL  = 4'd6;
  localparam logic [3:0] K_OPER    = 4'd7;
  localparam logic [3:0] K_INVALID = 4'd8;

  localparam logic [2:0] D_NONE       = 3'd0;
  localparam logic [2:0] D_UNKNOWN    = 3'd1;
  localparam logic [2:0] D_STR_NL     = 3'd2;
  localparam logic [2:0] D_STR_END    = 3'd3;
  localparam logic [2:0] D_BLOCK_END  = 3'd4;

  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_STAR  = 8'h2a;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic                    has_token;
    logic [3:0]              token_kind;
    logic [LINE_WIDTH-1:0]   token_line;
    logic [COLUMN_WIDTH-1:0] token_column;
    logic [OFFSET_WIDTH-1:0] token_offset;
    logic [LENGTH_WIDTH-1:0] token_length;
    logic [2:0]              diagnostic;
    logic                    last_of_run;
  } res_t;

  typedef res_t [MAX_RES-1:0] res_arr_t;

  typedef struct packed {
    logic                    skip_next;
    logic                    string_mode;
    logic                    line_comment_mode;
    logic                    block_comment_mode;
    logic [LINE_WIDTH-1:0]   line_count;
    logic [COLUMN_WIDTH-1:0] column_count;
    logic [OFFSET_WIDTH-1:0] byte_position;
    logic [COLUMN_WIDTH-1:0] start_column;
    logic [OFFSET_WIDTH-1:0] start_offset;
    logic [LENGTH_WIDTH-1:0] pending_length;
    logic [4:0]              class_state;
  } lex_state_t;

  function automatic lex_state_t reset_state();
    lex_state_t s;
    s = '0;
    s.line_count = LINE_WIDTH'(1);
    s.class_state = CS_EMPTY;
    return s;
  endfunction

  function automatic logic is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_hexd(logic [7:0] c);
    return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic nm_first(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || c == "."
        || c == "$";
  endfunction

  function automatic logic nm_rest(logic [7:0] c);
    return nm_first(c) || is_dig(c);
  endfunction

  // high bytes count as blank
  function automatic logic is_blank(logic [7:0] c);
    return c <= 8'h20 || c[7];
  endfunction

  function automatic logic is_sym(logic [7:0] c);
    return c == ";" || c == "{" || c == "}" || c == "(" || c == ")" || c == "["
        || c == "]" || c == ",";
  endfunction

  function automatic logic is_op(logic [7:0] c);
    return c == "+" || c == "-" || c == "*" || c == "/" || c == "%" || c == "&"
        || c == "|" || c == "^";
  endfunction

  function automatic logic [4:0] next_class(logic [4:0] s, logic [7:0] c);
    logic [4:0] r;
    r = CS_DEAD;
    if (s == CS_SOPEN || s == CS_SDONE || s == CS_SBAD) begin
      if (s == CS_SBAD || c == CH_NL || c == CH_CR) r = CS_SBAD;
      else r = (c == CH_QUOTE) ? CS_SDONE : CS_SOPEN;
    end else begin
      case (s)
        CS_EMPTY: begin
          if (c == CH_QUOTE) r = CS_SOPEN;
          else if (c == "0") r = CS_ZERO;
          else if (is_dig(c)) r = CS_DEC;
          else if (nm_first(c)) r = CS_NAME;
          else if (c == "@") r = CS_AT;
        end
        CS_ZERO: begin
          if (c == "x") r = CS_HEXP;
          else if (c == "b") r = CS_BINP;
          else if (c == "o") r = CS_OCTP;
          else if (is_dig(c)) r = CS_DEC;
          else if (c == ".") r = CS_FDOT;
        end
        CS_DEC: begin
          if (is_dig(c)) r = CS_DEC;
          else if (c == ".") r = CS_FDOT;
        end
        CS_FDOT, CS_FLT: if (is_dig(c)) r = CS_FLT;
        CS_HEXP, CS_HEX: if (is_hexd(c)) r = CS_HEX;
        CS_BINP, CS_BIN: if (c == "0" || c == "1") r = CS_BIN;
        CS_OCTP, CS_OCT: if (c >= "0" && c <= "7") r = CS_OCT;
        CS_NAME: begin
          if (nm_rest(c)) r = CS_NAME;
          else if (c == ":") r = CS_LABEL;
        end
        CS_AT: if (nm_first(c)) r = CS_REF;
        CS_REF: if (nm_rest(c)) r = CS_REF;
        default: r = CS_DEAD;
      endcase
    end
    return r;
  endfunction

  function automatic logic [3:0] kind_of(logic [4:0] s);
    logic [3:0] k;
    case (s)
      CS_FLT: k = K_FLOAT;
      CS_ZERO, CS_DEC, CS_HEX, CS_BIN, CS_OCT: k = K_INT;
      CS_SDONE: k = K_STRING;
      CS_NAME: k = K_NAME;
      CS_LABEL: k = K_LABEL;
      CS_REF: k = K_REF;
      default: k = K_INVALID;
    endcase
    return k;
  endfunction

  function automatic void put(input lex_state_t s, inout res_arr_t r, inout logic [2:0] cnt,
                              input logic has, input logic [3:0] kind,
                              input logic [LENGTH_WIDTH-1:0] len, input logic [2:0] diag);
    res_t e;
    e.has_token    = has;
    e.token_kind   = kind;
    e.token_line   = s.line_count;
    e.token_column = s.start_column;
    e.token_offset = s.start_offset;
    e.token_length = len;
    e.diagnostic   = diag;
    e.last_of_run  = 1'b0;
    if (cnt < 3'(MAX_RES)) begin
      r[cnt[1:0]] = e;
      cnt = cnt + 3'd1;
    end
  endfunction

  function automatic void report(input lex_state_t s, inout res_arr_t r,
                                 inout logic [2:0] cnt, input logic [2:0] silent);
    logic [3:0] k;
    logic [2:0] d;
    k = kind_of(s.class_state);
    d = (silent != D_NONE) ? silent : ((k == K_INVALID) ? D_UNKNOWN : D_NONE);
    put(s, r, cnt, 1'b1, k, s.pending_length, d);
  endfunction

  function automatic void add_char(inout lex_state_t s, input logic [7:0] c);
    s.class_state = next_class(s.class_state, c);
    if (s.pending_length != '1) s.pending_length = s.pending_length + 1'b1;
  endfunction

  function automatic void clear_token(inout lex_state_t s);
    s.class_state = CS_EMPTY;
    s.pending_length = '0;
  endfunction

  function automatic void handle_byte(inout lex_state_t s, input logic [7:0] c,
                                      input logic [7:0] n, inout res_arr_t r,
                                      inout logic [2:0] cnt);
    if (s.column_count != '1) s.column_count = s.column_count + 1'b1;
    if (s.skip_next) begin
      s.skip_next = 1'b0;
    end else if (c == CH_NL) begin
      if (s.string_mode) begin
        report(s, r, cnt, D_STR_NL);
        s.string_mode = 1'b0;
        clear_token(s);
      end
      if (s.class_state != CS_EMPTY) report(s, r, cnt, D_NONE);
      if (s.line_count != '1) s.line_count = s.line_count + 1'b1;
      s.column_count = '0;
      s.line_comment_mode = 1'b0;
      clear_token(s);
    end else if (s.line_comment_mode) begin
      // comment text is dropped
    end else if (s.block_comment_mode) begin
      if (c == CH_STAR && n == CH_SLASH) begin
        s.block_comment_mode = 1'b0;
        clear_token(s);
        s.skip_next = 1'b1;
      end
    end else if (c == CH_QUOTE) begin
      s.string_mode = !s.string_mode;
      add_char(s, c);
      if (!s.string_mode) begin
        report(s, r, cnt, D_NONE);
        clear_token(s);
      end
      s.start_column = s.column_count;
      s.start_offset = s.byte_position;
    end else if (s.string_mode) begin
      add_char(s, c);
      if (c == CH_BSL) begin
        add_char(s, n);
        s.skip_next = 1'b1;
      end
    end else if (is_blank(c) || is_sym(c) || is_op(c)) begin
      if (s.class_state != CS_EMPTY) begin
        report(s, r, cnt, D_NONE);
        clear_token(s);
      end
      if (c == CH_SLASH && n == CH_SLASH) begin
        s.line_comment_mode = 1'b1;
      end else if (c == CH_SLASH && n == CH_STAR) begin
        s.block_comment_mode = 1'b1;
        s.skip_next = 1'b1;
      end else if (!is_blank(c)) begin
        s.start_column = s.column_count;
        s.start_offset = s.byte_position;
        put(s, r, cnt, 1'b1, is_sym(c) ? K_SYMBOL : K_OPER, LENGTH_WIDTH'(1), D_NONE);
      end
    end else begin
      if (s.class_state == CS_EMPTY) begin
        s.start_column = s.column_count;
        s.start_offset = s.byte_position;
      end
      add_char(s, c);
    end
    if (s.byte_position != '1) s.byte_position = s.byte_position + 1'b1;
  endfunction

endpackage

// ===== rtl/asl_in_if.sv =====
// ----------------------------------------------------------------------------
// asl_in_if
// Source byte channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface asl_in_if;
  import asl_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       is_last;
  modport source (output valid, output char_byte, output is_last, input ready);
  modport sink (input valid, input char_byte, input is_last, output ready);
endinterface

// ===== rtl/asl_out_if.sv =====
// ----------------------------------------------------------------------------
// asl_out_if
// Token result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface asl_out_if;
  import asl_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    has_token;
  logic [3:0]              token_kind;
  logic [LINE_WIDTH-1:0]   token_line;
  logic [COLUMN_WIDTH-1:0] token_column;
  logic [OFFSET_WIDTH-1:0] token_offset;
  logic [LENGTH_WIDTH-1:0] token_length;
  logic [2:0]              diagnostic;
  logic                    last_of_run;
  modport source (output valid, output has_token, output token_kind, output token_line,
                  output token_column, output token_offset, output token_length,
                  output diagnostic, output last_of_run, input ready);
  modport sink (input valid, input has_token, input token_kind, input token_line,
                input token_column, input token_offset, input token_length,
                input diagnostic, input last_of_run, output ready);
endinterface

// ===== rtl/assembly_source_lexer_core.sv =====
// ----------------------------------------------------------------------------
// assembly_source_lexer_core
// Streaming lexer: bytes in, token and diagnostic results out.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  in_ch     in   char_byte, is_last
//  out_ch    out  has_token, kind, line, column, offset, length, diagnostic,
//                 last_of_run
//
//  one byte accepted per cycle while the result queue has room for four
//  results; each byte yields 0 to 4 results, drained one per cycle, so the
//  output drain rate sets throughput when results outnumber bytes.
//  synchronous reset clears lexer state and the queue.
//  a stalled output just fills the queue; input stalls once more than four
//  results are queued.
module assembly_source_lexer_core
  import asl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  asl_in_if.sink    in_ch,
  asl_out_if.source out_ch
);

  localparam int QDEPTH = 2 * MAX_RES;
  localparam int QW     = $clog2(QDEPTH);

  lex_state_t   st;
  logic [7:0]   held_byte;
  logic         held_valid;
  res_t         queue [QDEPTH];
  logic [QW-1:0] wptr;
  logic [QW-1:0] rptr;
  logic [QW:0]   count;

  lex_state_t   st_next;
  res_arr_t     res;
  logic [2:0]   res_cnt;
  logic         in_fire;
  logic         out_fire;

  assign in_ch.ready = count <= (QW+1)'(MAX_RES);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  always_comb begin
    st_next = st;
    res = '0;
    res_cnt = '0;
    if (held_valid) handle_byte(st_next, held_byte, in_ch.char_byte, res, res_cnt);
    if (in_ch.is_last) begin
      handle_byte(st_next, in_ch.char_byte, 8'h00, res, res_cnt);
      if (st_next.block_comment_mode)
        put(st_next, res, res_cnt, 1'b0, K_FLOAT, '0, D_BLOCK_END);
      if (st_next.string_mode) begin
        report(st_next, res, res_cnt, D_STR_END);
        clear_token(st_next);
      end
      if (st_next.class_state != CS_EMPTY) report(st_next, res, res_cnt, D_NONE);
      st_next = reset_state();
    end
    if (res_cnt != 3'd0) res[2'(res_cnt - 3'd1)].last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= reset_state();
      held_byte <= '0;
      held_valid <= 1'b0;
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (in_fire) begin
        st <= st_next;
        held_byte <= in_ch.char_byte;
        held_valid <= !in_ch.is_last;
        wptr <= wptr + QW'(res_cnt);
      end
      if (out_fire) rptr <= rptr + 1'b1;
      count <= count + (in_fire ? (QW+1)'(res_cnt) : '0) - (QW+1)'(out_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < MAX_RES; i++) begin
        if (3'(i) < res_cnt) queue[QW'(wptr + QW'(i))] <= res[i];
      end
    end
  end

  assign out_ch.valid        = count != '0;
  assign out_ch.has_token    = queue[rptr].has_token;
  assign out_ch.token_kind   = queue[rptr].token_kind;
  assign out_ch.token_line   = queue[rptr].token_line;
  assign out_ch.token_column = queue[rptr].token_column;
  assign out_ch.token_offset = queue[rptr].token_offset;
  assign out_ch.token_length = queue[rptr].token_length;
  assign out_ch.diagnostic   = queue[rptr].diagnostic;
  assign out_ch.last_of_run  = queue[rptr].last_of_run;

endmodule
